### rtl/vei_pkg.sv
// Shared constants, types and the exp2 lookup table of the vector easing interpolator.
`default_nettype none

package vei_pkg;

    // Progress format, exp2 table size and queue depth
    localparam int PROGRESS_FRAC_BITS = 16;
    localparam int EXP_TABLE_ENTRIES  = 64;
    localparam int QUEUE_DEPTH        = 4;

    localparam int P    = PROGRESS_FRAC_BITS;
    localparam int TW   = P + 1;                 // progress / weight width
    localparam int OPW  = P + 2;                 // quadratic operand width
    localparam int MW   = 2 * OPW;               // quadratic product width
    localparam int XW   = P + 4;                 // exponent argument, up to 10.0
    localparam int NW   = XW - P;                // integer part of the exponent
    localparam int IDXW = $clog2(EXP_TABLE_ENTRIES);
    localparam int RIW  = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int POSW = P + IDXW;
    localparam int ROMW = 31;                    // Q30 samples, up to 1.0
    localparam int SW   = 5;                     // final shift amount width
    localparam int VW   = 32;                    // vector component width
    localparam int DW   = VW + 1;                // goal minus start width

    localparam int EXP_SCALE = 10;
    localparam int S_BASE    = 30 - P;

    localparam logic [TW-1:0]  ONE_Q  = TW'(1) << P;
    localparam logic [TW-1:0]  HALF_Q = TW'(1) << (P - 1);
    localparam logic [OPW-1:0] ONE_OP = OPW'(1) << P;
    localparam logic [OPW-1:0] TWO_OP = OPW'(1) << (P + 1);

    localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW - 1){1'b1}}};
    localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW - 1){1'b0}}};

    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Curve codes on req_type
    localparam logic [2:0] CURVE_IN_QUAD    = 3'd0;
    localparam logic [2:0] CURVE_OUT_QUAD   = 3'd1;
    localparam logic [2:0] CURVE_INOUT_QUAD = 3'd2;
    localparam logic [2:0] CURVE_LINEAR     = 3'd3;
    localparam logic [2:0] CURVE_IN_EXP     = 3'd4;
    localparam logic [2:0] CURVE_OUT_EXP    = 3'd5;

    // How the weight is formed from the classified operands
    typedef enum logic [2:0] {
        KIND_ZERO     = 3'd0,
        KIND_SQR_RND  = 3'd1,
        KIND_SQR_DBL  = 3'd2,
        KIND_INOUT_HI = 3'd3,
        KIND_LINEAR   = 3'd4,
        KIND_EXP_IN   = 3'd5,
        KIND_EXP_OUT  = 3'd6
    } kind_t;

    typedef logic [2:0][VW-1:0] vec3_t;
    typedef logic [2:0][DW-1:0] dvec3_t;

    typedef struct packed {
        kind_t          kind;
        logic [OPW-1:0] op_a;
        logic [OPW-1:0] op_b;
        logic [XW-1:0]  x_arg;
        vec3_t          start;
        dvec3_t         diff;
    } item_t;

    typedef struct packed {
        logic [TW-1:0] weight;
        vec3_t         start;
        dvec3_t        diff;
    } eased_t;

    typedef logic [ROMW-1:0] exp_rom_t [0:EXP_TABLE_ENTRIES];

    // Samples of 2^(-i/N) in Q30 from a truncated Taylor series; last entry is 0.5.
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic        done;
        for (int i = 0; i <= EXP_TABLE_ENTRIES; i++)
        begin
            y    = (64'(i) * LN2_Q30 + 64'(EXP_TABLE_ENTRIES / 2)) / 64'(EXP_TABLE_ENTRIES);
            sum  = Q30_ONE;
            term = Q30_ONE;
            done = 1'b0;
            for (int k = 1; k <= 24; k++)
            begin
                if (!done)
                begin
                    term = ((term * y) >> 30) / 64'(k);
                    if (term == 64'd0)
                        done = 1'b1;
                    else if ((k & 1) == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
            end
            rom[i] = sum[ROMW-1:0];
        end
        rom[EXP_TABLE_ENTRIES] = ROMW'(Q30_ONE >> 1);
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

### rtl/vei_front.sv
// Front stage: accept a request word, clamp progress and classify the curve.
`default_nettype none

module vei_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire logic [2:0]                   req_type,
    input  wire logic [vei_pkg::TW-1:0]       progress,
    input  wire logic signed [vei_pkg::VW-1:0] start_x,
    input  wire logic signed [vei_pkg::VW-1:0] start_y,
    input  wire logic signed [vei_pkg::VW-1:0] start_z,
    input  wire logic signed [vei_pkg::VW-1:0] goal_x,
    input  wire logic signed [vei_pkg::VW-1:0] goal_y,
    input  wire logic signed [vei_pkg::VW-1:0] goal_z,
    output logic                              item_valid,
    input  wire logic                         item_ready,
    output vei_pkg::item_t                    item
);

    logic                           front_valid_reg;
    vei_pkg::item_t                 item_reg;
    vei_pkg::item_t                 item_next;
    logic [vei_pkg::TW-1:0]         t_clamp;
    logic [vei_pkg::OPW-1:0]        t_op;
    logic [vei_pkg::OPW-1:0]        u_op;

    assign req_ready  = !front_valid_reg || item_ready;
    assign item_valid = front_valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        t_clamp = (progress > vei_pkg::ONE_Q) ? vei_pkg::ONE_Q : progress;
        t_op    = vei_pkg::OPW'(t_clamp);
        u_op    = (t_op << 1) - vei_pkg::ONE_OP;

        item_next.kind  = vei_pkg::KIND_ZERO;
        item_next.op_a  = t_op;
        item_next.op_b  = t_op;
        item_next.x_arg = '0;

        unique case (req_type)
            vei_pkg::CURVE_IN_QUAD:
            begin
                item_next.kind = vei_pkg::KIND_SQR_RND;
            end
            vei_pkg::CURVE_OUT_QUAD:
            begin
                item_next.kind = vei_pkg::KIND_SQR_RND;
                item_next.op_b = vei_pkg::TWO_OP - t_op;
            end
            vei_pkg::CURVE_INOUT_QUAD:
            begin
                if (t_clamp < vei_pkg::HALF_Q)
                begin
                    item_next.kind = vei_pkg::KIND_SQR_DBL;
                end
                else
                begin
                    item_next.kind = vei_pkg::KIND_INOUT_HI;
                    item_next.op_a = u_op;
                    item_next.op_b = vei_pkg::TWO_OP - u_op;
                end
            end
            vei_pkg::CURVE_LINEAR:
            begin
                item_next.kind = vei_pkg::KIND_LINEAR;
            end
            vei_pkg::CURVE_IN_EXP:
            begin
                // zero progress pins the curve to zero
                if (t_clamp != '0)
                    item_next.kind = vei_pkg::KIND_EXP_IN;
                item_next.x_arg = vei_pkg::XW'(vei_pkg::EXP_SCALE)
                                * vei_pkg::XW'(vei_pkg::ONE_Q - t_clamp);
            end
            vei_pkg::CURVE_OUT_EXP:
            begin
                // full progress pins the curve to one: pass t through as linear
                if (t_clamp == vei_pkg::ONE_Q)
                    item_next.kind = vei_pkg::KIND_LINEAR;
                else
                    item_next.kind = vei_pkg::KIND_EXP_OUT;
                item_next.x_arg = vei_pkg::XW'(vei_pkg::EXP_SCALE) * vei_pkg::XW'(t_clamp);
            end
            default:
            begin
                item_next.kind = vei_pkg::KIND_ZERO;
            end
        endcase

        item_next.start[0] = start_x;
        item_next.start[1] = start_y;
        item_next.start[2] = start_z;
        item_next.diff[0]  = vei_pkg::DW'(goal_x) - vei_pkg::DW'(start_x);
        item_next.diff[1]  = vei_pkg::DW'(goal_y) - vei_pkg::DW'(start_y);
        item_next.diff[2]  = vei_pkg::DW'(goal_z) - vei_pkg::DW'(start_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else if (req_ready)
            front_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

### rtl/vei_queue.sv
// Short queue between the classifying front and the evaluating back end.
`default_nettype none

module vei_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire vei_pkg::item_t push_item,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output vei_pkg::item_t      pop_item
);

    localparam int PTRW = $clog2(vei_pkg::QUEUE_DEPTH);
    localparam int CW   = $clog2(vei_pkg::QUEUE_DEPTH + 1);

    vei_pkg::item_t   slot_reg [vei_pkg::QUEUE_DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CW'(vei_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTRW'(vei_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + PTRW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTRW'(vei_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + PTRW'(1);
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    a_fill_counts_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CW'(1))
    else $error("queue count did not advance on a lone push");

    a_drain_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - CW'(1))
    else $error("queue count did not drop on a lone pop");

    a_empty_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
    else $error("queue empty but pointers differ");

endmodule

`default_nettype wire

### rtl/vei_curve.sv
// Back end, first half: evaluate the easing weight over four pipeline stages.
`default_nettype none

module vei_curve (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire vei_pkg::item_t item,
    output logic                eased_valid,
    input  wire logic           eased_ready,
    output vei_pkg::eased_t     eased
);

    localparam int P    = vei_pkg::P;
    localparam int IPW  = vei_pkg::ROMW + P;
    localparam int IPW1 = IPW + 1;
    localparam int GW   = vei_pkg::ROMW + 1;
    localparam int QW   = vei_pkg::MW + 2;

    localparam logic [IPW1-1:0] HALF_IP = IPW1'(1) << (P - 1);
    localparam logic [QW-1:0]   HALF_QW = QW'(1) << (P - 1);
    localparam logic [QW-1:0]   ONE_QW  = QW'(1) << P;
    localparam logic [QW-1:0]   ONE_SQ  = QW'(1) << (2 * P);

    typedef struct packed {
        vei_pkg::kind_t                   kind;
        logic [vei_pkg::OPW-1:0]          op_a;
        logic [vei_pkg::MW-1:0]           prod;
        logic [vei_pkg::IDXW-1:0]         idx;
        logic [P-1:0]                     frac;
        logic [vei_pkg::SW-1:0]           shift;
        vei_pkg::vec3_t                   start;
        vei_pkg::dvec3_t                  diff;
    } st1_t;

    typedef struct packed {
        vei_pkg::kind_t                   kind;
        logic [vei_pkg::OPW-1:0]          op_a;
        logic [vei_pkg::MW-1:0]           prod;
        logic [vei_pkg::ROMW-1:0]         hi;
        logic [vei_pkg::ROMW-1:0]         delta;
        logic [P-1:0]                     frac;
        logic [vei_pkg::SW-1:0]           shift;
        vei_pkg::vec3_t                   start;
        vei_pkg::dvec3_t                  diff;
    } st2_t;

    typedef struct packed {
        vei_pkg::kind_t                   kind;
        logic [vei_pkg::OPW-1:0]          op_a;
        logic [vei_pkg::MW-1:0]           prod;
        logic [vei_pkg::ROMW-1:0]         hi;
        logic [IPW-1:0]                   ip;
        logic [vei_pkg::SW-1:0]           shift;
        vei_pkg::vec3_t                   start;
        vei_pkg::dvec3_t                  diff;
    } st3_t;

    logic            s1_valid_reg;
    logic            s2_valid_reg;
    logic            s3_valid_reg;
    logic            s4_valid_reg;
    st1_t            s1_reg;
    st1_t            s1_next;
    st2_t            s2_reg;
    st2_t            s2_next;
    st3_t            s3_reg;
    st3_t            s3_next;
    vei_pkg::eased_t s4_reg;
    vei_pkg::eased_t s4_next;
    logic            adv1;
    logic            adv2;
    logic            adv3;
    logic            adv4;

    logic [vei_pkg::POSW-1:0] pos;
    logic [vei_pkg::RIW-1:0]  rom_idx;
    logic [vei_pkg::ROMW-1:0] rom_lo;
    logic [IPW1-1:0]          ip_rnd;
    logic [vei_pkg::ROMW-1:0] g;
    logic [GW-1:0]            g_rnd;
    logic [vei_pkg::TW-1:0]   pw;
    logic [QW-1:0]            sq_rnd;
    logic [QW-1:0]            sq_dbl;
    logic [QW-1:0]            io_hi;

    assign adv4        = !s4_valid_reg || eased_ready;
    assign adv3        = !s3_valid_reg || adv4;
    assign adv2        = !s2_valid_reg || adv3;
    assign adv1        = !s1_valid_reg || adv2;
    assign item_ready  = adv1;
    assign eased_valid = s4_valid_reg;
    assign eased       = s4_reg;

    // Stage 1: quadratic product, split the exponent into table index and fraction
    always_comb
    begin
        pos           = vei_pkg::POSW'(item.x_arg[P-1:0])
                      * vei_pkg::POSW'(vei_pkg::EXP_TABLE_ENTRIES);
        s1_next.kind  = item.kind;
        s1_next.op_a  = item.op_a;
        s1_next.prod  = vei_pkg::MW'(item.op_a) * vei_pkg::MW'(item.op_b);
        s1_next.idx   = pos[vei_pkg::POSW-1:P];
        s1_next.frac  = pos[P-1:0];
        s1_next.shift = vei_pkg::SW'(vei_pkg::S_BASE)
                      + vei_pkg::SW'(item.x_arg[vei_pkg::XW-1:P]);
        s1_next.start = item.start;
        s1_next.diff  = item.diff;
    end

    // Stage 2: read the two neighboring table samples
    always_comb
    begin
        rom_idx       = vei_pkg::RIW'(s1_reg.idx);
        rom_lo        = vei_pkg::EXP_ROM[rom_idx + vei_pkg::RIW'(1)];
        s2_next.kind  = s1_reg.kind;
        s2_next.op_a  = s1_reg.op_a;
        s2_next.prod  = s1_reg.prod;
        s2_next.hi    = vei_pkg::EXP_ROM[rom_idx];
        s2_next.delta = vei_pkg::EXP_ROM[rom_idx] - rom_lo;
        s2_next.frac  = s1_reg.frac;
        s2_next.shift = s1_reg.shift;
        s2_next.start = s1_reg.start;
        s2_next.diff  = s1_reg.diff;
    end

    // Stage 3: interpolation product
    always_comb
    begin
        s3_next.kind  = s2_reg.kind;
        s3_next.op_a  = s2_reg.op_a;
        s3_next.prod  = s2_reg.prod;
        s3_next.hi    = s2_reg.hi;
        s3_next.ip    = IPW'(s2_reg.delta) * IPW'(s2_reg.frac);
        s3_next.shift = s2_reg.shift;
        s3_next.start = s2_reg.start;
        s3_next.diff  = s2_reg.diff;
    end

    // Stage 4: round, shift and pick the weight
    always_comb
    begin
        ip_rnd = (IPW1'(s3_reg.ip) + HALF_IP) >> P;
        g      = s3_reg.hi - ip_rnd[vei_pkg::ROMW-1:0];
        g_rnd  = (GW'(g) + (GW'(1) << (s3_reg.shift - vei_pkg::SW'(1)))) >> s3_reg.shift;
        pw     = g_rnd[vei_pkg::TW-1:0];
        sq_rnd = (QW'(s3_reg.prod) + HALF_QW) >> P;
        sq_dbl = ((QW'(s3_reg.prod) << 1) + HALF_QW) >> P;
        io_hi  = (ONE_SQ + QW'(s3_reg.prod) + ONE_QW) >> (P + 1);

        unique case (s3_reg.kind)
            vei_pkg::KIND_ZERO:     s4_next.weight = '0;
            vei_pkg::KIND_SQR_RND:  s4_next.weight = sq_rnd[vei_pkg::TW-1:0];
            vei_pkg::KIND_SQR_DBL:  s4_next.weight = sq_dbl[vei_pkg::TW-1:0];
            vei_pkg::KIND_INOUT_HI: s4_next.weight = io_hi[vei_pkg::TW-1:0];
            vei_pkg::KIND_LINEAR:   s4_next.weight = s3_reg.op_a[vei_pkg::TW-1:0];
            vei_pkg::KIND_EXP_IN:   s4_next.weight = pw;
            vei_pkg::KIND_EXP_OUT:  s4_next.weight = vei_pkg::ONE_Q - pw;
            default:                s4_next.weight = '0;
        endcase

        s4_next.start = s3_reg.start;
        s4_next.diff  = s3_reg.diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= item_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
            if (adv4)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && item_valid)
            s1_reg <= s1_next;
        if (adv2 && s1_valid_reg)
            s2_reg <= s2_next;
        if (adv3 && s2_valid_reg)
            s3_reg <= s3_next;
        if (adv4 && s3_valid_reg)
            s4_reg <= s4_next;
    end

    a_weight_in_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> s4_reg.weight <= vei_pkg::ONE_Q)
    else $error("easing weight above one");

endmodule

`default_nettype wire

### rtl/vei_blend.sv
// Back end, second half: scale the difference, round, add the start and saturate.
`default_nettype none

module vei_blend (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             eased_valid,
    output logic                  eased_ready,
    input  wire vei_pkg::eased_t  eased,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output logic signed [vei_pkg::VW-1:0] value_x,
    output logic signed [vei_pkg::VW-1:0] value_y,
    output logic signed [vei_pkg::VW-1:0] value_z,
    output logic                  saturated
);

    localparam int P    = vei_pkg::P;
    localparam int PW   = vei_pkg::DW + vei_pkg::TW + 1;
    localparam int RW   = PW - P;
    localparam int SUMW = RW + 1;

    localparam logic [PW-1:0] HALF_PW = PW'(1) << (P - 1);

    logic                          b1_valid_reg;
    logic                          b2_valid_reg;
    logic [2:0][PW-1:0]            prod_reg;
    logic [2:0][PW-1:0]            prod_next;
    vei_pkg::vec3_t                start_reg;
    logic [2:0][vei_pkg::VW-1:0]   value_reg;
    logic [2:0][vei_pkg::VW-1:0]   value_next;
    logic                          sat_reg;
    logic                          sat_next;
    logic signed [PW-1:0]          biased;
    logic signed [PW-1:0]          shifted;
    logic signed [SUMW-1:0]        sum;
    logic                          adv1;
    logic                          adv2;

    assign adv2        = !b2_valid_reg || res_ready;
    assign adv1        = !b1_valid_reg || adv2;
    assign eased_ready = adv1;
    assign res_valid   = b2_valid_reg;
    assign value_x     = value_reg[0];
    assign value_y     = value_reg[1];
    assign value_z     = value_reg[2];
    assign saturated   = sat_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_next[c] = PW'($signed(eased.diff[c])) * PW'($signed({1'b0, eased.weight}));
        end
    end

    // Round to nearest with ties up, add start, clamp to the 32-bit range
    always_comb
    begin
        sat_next = 1'b0;
        biased   = '0;
        shifted  = '0;
        sum      = '0;
        for (int c = 0; c < 3; c++)
        begin
            biased  = $signed(prod_reg[c]) + $signed(HALF_PW);
            shifted = biased >>> P;
            sum     = SUMW'($signed(shifted[RW-1:0])) + SUMW'($signed(start_reg[c]));
            if ((sum[SUMW-1:vei_pkg::VW-1] != '0) && (sum[SUMW-1:vei_pkg::VW-1] != '1))
            begin
                value_next[c] = sum[SUMW-1] ? vei_pkg::VAL_MIN : vei_pkg::VAL_MAX;
                sat_next      = 1'b1;
            end
            else
            begin
                value_next[c] = sum[vei_pkg::VW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                b1_valid_reg <= eased_valid;
            if (adv2)
                b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && eased_valid)
        begin
            prod_reg  <= prod_next;
            start_reg <= eased.start;
        end
        if (adv2 && b1_valid_reg)
        begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

endmodule

`default_nettype wire

### rtl/vector_easing_interpolator.sv
// Top level of the vector easing interpolator: front, queue and back end.
`default_nettype none

// Eases a 3-vector from start toward goal: each component becomes
// start + round((goal - start) * f(t)), where f is one of the quadratic
// in, out or in-out curves, linear, or the exponential in or out curve,
// picked by req_type (codes 6 and 7 give f = 0, i.e. the start vector).
// Progress is unsigned with 16 fraction bits and is clamped to 1.0; vectors
// are signed Q16.16 and results are clamped to the 32-bit range, with
// saturated set when any component was clamped. The exponential term comes
// from a 65-sample table of 2^(-x) with linear interpolation and a shift.
// The block takes one request word per clock and returns one result word
// per clock when neither side stalls; a word passes through one front stage,
// the queue, four weight stages and two scale and saturate stages.
// A four-word queue between the front and the back end lets each side stall
// independently; every stage holds its word while the stage after it is
// full. There is no state between words and no startup sweep after reset.
module vector_easing_interpolator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [2:0]                    req_type,
    input  wire logic [vei_pkg::TW-1:0]        progress,
    input  wire logic signed [vei_pkg::VW-1:0] start_x,
    input  wire logic signed [vei_pkg::VW-1:0] start_y,
    input  wire logic signed [vei_pkg::VW-1:0] start_z,
    input  wire logic signed [vei_pkg::VW-1:0] goal_x,
    input  wire logic signed [vei_pkg::VW-1:0] goal_y,
    input  wire logic signed [vei_pkg::VW-1:0] goal_z,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic signed [vei_pkg::VW-1:0]      value_x,
    output logic signed [vei_pkg::VW-1:0]      value_y,
    output logic signed [vei_pkg::VW-1:0]      value_z,
    output logic                               saturated
);

    // front -> queue
    logic            fq_valid;
    logic            fq_ready;
    vei_pkg::item_t  fq_item;
    // queue -> weight pipeline
    logic            qc_valid;
    logic            qc_ready;
    vei_pkg::item_t  qc_item;
    // weight pipeline -> blend
    logic            cb_valid;
    logic            cb_ready;
    vei_pkg::eased_t cb_eased;

    // Classify the request and hold it until the queue has room
    vei_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .progress   (progress),
        .start_x    (start_x),
        .start_y    (start_y),
        .start_z    (start_z),
        .goal_x     (goal_x),
        .goal_y     (goal_y),
        .goal_z     (goal_z),
        .item_valid (fq_valid),
        .item_ready (fq_ready),
        .item       (fq_item)
    );

    // Absorb back-end stalls until the queue is full; then the front blocks
    vei_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qc_valid),
        .pop_ready  (qc_ready),
        .pop_item   (qc_item)
    );

    // Evaluate the easing weight f(t)
    vei_curve u_curve (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (qc_valid),
        .item_ready  (qc_ready),
        .item        (qc_item),
        .eased_valid (cb_valid),
        .eased_ready (cb_ready),
        .eased       (cb_eased)
    );

    // Scale, round, add the start vector and saturate into the output register
    vei_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .eased_valid (cb_valid),
        .eased_ready (cb_ready),
        .eased       (cb_eased),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .value_x     (value_x),
        .value_y     (value_y),
        .value_z     (value_z),
        .saturated   (saturated)
    );

    // With the weight bounded by one, the blend stays between start and goal
    a_no_clamp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !saturated)
    else $error("result clamped although the weight lies in the unit range");

endmodule

`default_nettype wire

### sim/tb_vector_easing_interpolator.sv
// Self-checking testbench for the vector easing interpolator: curve predictor, scoreboard, drivers.

// One request word as it is put on the input ports; index 0 is x, 1 is y, 2 is z.
typedef struct packed {
    logic [2:0]                kind;
    logic [vei_pkg::TW-1:0]    prog;
    logic [2:0][31:0]          start_v;
    logic [2:0][31:0]          goal_v;
} ease_req_t;

// One result word as the block should return it.
typedef struct packed {
    logic [2:0][31:0]  value;
    logic              sat;
} eased_vec_t;

class easing_scoreboard;
    eased_vec_t  expected_q[$];
    bit [63:0]   exp2_samples[vei_pkg::EXP_TABLE_ENTRIES + 1];
    int          mismatches;
    int          results_checked;
    int          requests_seen;
    int          over_one_seen;
    int          curve_seen[8];

    // Fill the 2^(-i/N) samples in Q30 from a truncated Taylor series of exp(-y).
    function new();
        longint unsigned y;
        longint unsigned term;
        longint          acc;
        for (int i = 0; i <= vei_pkg::EXP_TABLE_ENTRIES; i++)
        begin
            // y = i/N * ln(2), with ln(2) in Q30
            y    = (longint'(i) * 64'd744261118 + vei_pkg::EXP_TABLE_ENTRIES / 2)
                 / vei_pkg::EXP_TABLE_ENTRIES;
            acc  = longint'(1) << 30;
            term = 64'd1 << 30;
            for (int k = 1; k <= 24; k++)
            begin
                term = ((term * y) >> 30) / k;
                if (term == 0)
                    break;
                acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            exp2_samples[i] = acc;
        end
        exp2_samples[vei_pkg::EXP_TABLE_ENTRIES] = 64'd1 << 29;
        for (int i = 0; i < 8; i++)
            curve_seen[i] = 0;
        mismatches      = 0;
        results_checked = 0;
        requests_seen   = 0;
        over_one_seen   = 0;
    endfunction

    // 2^(-x) for x with P fraction bits, result with P fraction bits.
    function bit [63:0] exp2_neg(bit [63:0] x);
        bit [63:0] whole;
        bit [63:0] frac;
        bit [63:0] pos;
        bit [63:0] idx;
        bit [63:0] w;
        bit [63:0] g;
        bit [63:0] sh;
        whole = x >> vei_pkg::P;
        if (whole > 30)
            return 64'd0;
        frac = x & ((64'd1 << vei_pkg::P) - 1);
        pos  = frac * vei_pkg::EXP_TABLE_ENTRIES;
        idx  = pos >> vei_pkg::P;
        w    = pos & ((64'd1 << vei_pkg::P) - 1);
        g    = exp2_samples[idx]
             - (((exp2_samples[idx] - exp2_samples[idx + 1]) * w
                 + (64'd1 << (vei_pkg::P - 1))) >> vei_pkg::P);
        sh   = 30 - vei_pkg::P + whole;
        return (g + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // Easing weight f(t), unsigned with P fraction bits; t is already clamped to one.
    function bit [63:0] ease_weight(logic [2:0] kind, bit [63:0] t);
        bit [63:0] unit_w;
        bit [63:0] half_w;
        bit [63:0] u;
        unit_w = 64'd1 << vei_pkg::P;
        half_w = unit_w >> 1;
        case (kind)
            vei_pkg::CURVE_IN_QUAD:
                return (t * t + half_w) >> vei_pkg::P;
            vei_pkg::CURVE_OUT_QUAD:
                return (t * (2 * unit_w - t) + half_w) >> vei_pkg::P;
            vei_pkg::CURVE_INOUT_QUAD:
            begin
                if (2 * t < unit_w)
                    return (2 * t * t + half_w) >> vei_pkg::P;
                u = 2 * t - unit_w;
                return (unit_w * unit_w + u * (2 * unit_w - u) + unit_w) >> (vei_pkg::P + 1);
            end
            vei_pkg::CURVE_LINEAR:
                return t;
            vei_pkg::CURVE_IN_EXP:
                return (t == 0) ? 64'd0 : exp2_neg(10 * (unit_w - t));
            vei_pkg::CURVE_OUT_EXP:
                return (t == unit_w) ? unit_w : unit_w - exp2_neg(10 * t);
            default:
                return 64'd0;
        endcase
    endfunction

    // start + round((goal - start) * w), before clamping.
    function longint blend(logic [31:0] st_bits, logic [31:0] gl_bits, bit [63:0] w);
        longint st;
        longint gl;
        longint prod;
        st   = longint'(signed'(st_bits));
        gl   = longint'(signed'(gl_bits));
        prod = (gl - st) * longint'(w);
        return st + ((prod + (longint'(1) << (vei_pkg::P - 1))) >>> vei_pkg::P);
    endfunction

    function void note_request(ease_req_t r);
        bit [63:0]  t;
        bit [63:0]  w;
        longint     v;
        eased_vec_t want;
        t = r.prog;
        if (t > (64'd1 << vei_pkg::P))
        begin
            t = 64'd1 << vei_pkg::P;
            over_one_seen++;
        end
        w = ease_weight(r.kind, t);
        want.sat = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            v = blend(r.start_v[c], r.goal_v[c], w);
            if (v > 64'sh7FFF_FFFF)
            begin
                v = 64'sh7FFF_FFFF;
                want.sat = 1'b1;
            end
            else if (v < -64'sh8000_0000)
            begin
                v = -64'sh8000_0000;
                want.sat = 1'b1;
            end
            want.value[c] = v[31:0];
        end
        expected_q.push_back(want);
        requests_seen++;
        curve_seen[r.kind]++;
    endfunction

    function int outstanding();
        return expected_q.size();
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("MISMATCH: %s", what);
    endtask

    task check_result(logic [2:0][31:0] got, logic got_sat);
        eased_vec_t want;
        string      axes;
        axes = "xyz";
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h %h %h sat %b",
                                      got[0], got[1], got[2], got_sat));
            return;
        end
        want = expected_q.pop_front();
        results_checked++;
        for (int c = 0; c < 3; c++)
            if (got[c] !== want.value[c])
                report_mismatch($sformatf("word %0d value_%s got %h want %h", results_checked,
                                          axes.substr(c, c), got[c], want.value[c]));
        if (got_sat !== want.sat)
            report_mismatch($sformatf("word %0d saturated got %b want %b",
                                      results_checked, got_sat, want.sat));
    endtask
endclass

module tb_vector_easing_interpolator;

    // Curve codes the block treats as "no easing": result is the start vector.
    localparam logic [2:0] CURVE_SPARE_6 = 3'd6;
    localparam logic [2:0] CURVE_SPARE_7 = 3'd7;

    localparam int DIRECTED_COUNT = 20;
    localparam int RANDOM_COUNT   = 1080;
    localparam int HOLD_CYCLES    = 64;     // long receiver hold-off, fills queue and pipe
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no word moving on either side

    // Directed words: the in-quad endpoints, out-quad at one half and just below one,
    // the in-out seam at one half, progress above one, the exponential endpoints and the unused codes.
    localparam logic [2:0] DIR_KIND [DIRECTED_COUNT] = '{
        vei_pkg::CURVE_IN_QUAD,    vei_pkg::CURVE_IN_QUAD,
        vei_pkg::CURVE_OUT_QUAD,   vei_pkg::CURVE_OUT_QUAD,
        vei_pkg::CURVE_INOUT_QUAD, vei_pkg::CURVE_INOUT_QUAD,
        vei_pkg::CURVE_INOUT_QUAD, vei_pkg::CURVE_LINEAR,
        vei_pkg::CURVE_LINEAR,     vei_pkg::CURVE_IN_EXP,
        vei_pkg::CURVE_IN_EXP,     vei_pkg::CURVE_IN_EXP,
        vei_pkg::CURVE_OUT_EXP,    vei_pkg::CURVE_OUT_EXP,
        vei_pkg::CURVE_OUT_EXP,    CURVE_SPARE_6,
        CURVE_SPARE_7,             vei_pkg::CURVE_IN_EXP,
        vei_pkg::CURVE_OUT_EXP,    vei_pkg::CURVE_LINEAR
    };
    localparam logic [vei_pkg::TW-1:0] DIR_PROG [DIRECTED_COUNT] = '{
        17'd0,      17'd65536, 17'd32768, 17'd65535,
        17'd32767,  17'd32768, 17'd65535, 17'd131071,
        17'd65537,  17'd0,     17'd1,     17'd65536,
        17'd65536,  17'd0,     17'd65535, 17'd40000,
        17'd65536,  17'd6554,  17'd131071, 17'd1
    };
    localparam logic [31:0] EXTREMES [5] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001
    };

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_ready;
    logic [2:0]                req_type;
    logic [vei_pkg::TW-1:0]    progress;
    logic signed [31:0]        start_x;
    logic signed [31:0]        start_y;
    logic signed [31:0]        start_z;
    logic signed [31:0]        goal_x;
    logic signed [31:0]        goal_y;
    logic signed [31:0]        goal_z;
    logic                      res_valid;
    logic                      res_ready;
    logic signed [31:0]        value_x;
    logic signed [31:0]        value_y;
    logic signed [31:0]        value_z;
    logic                      saturated;

    easing_scoreboard    sb;
    bit                  hold_req = 1'b0;   // ask the receiver for one long hold-off
    int                  hold_count = 0;
    int                  drain_count = 0;
    int                  quiet_cycles = 0;

    vector_easing_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .progress  (progress),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .goal_x    (goal_x),
        .goal_y    (goal_y),
        .goal_z    (goal_z),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .value_x   (value_x),
        .value_y   (value_y),
        .value_z   (value_z),
        .saturated (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Put one request word on the ports at the falling edge and hold it until the
    // block takes it. Valid stays high into the next word when no gap follows.
    task automatic offer_request(input ease_req_t r);
        @(negedge clk);
        req_valid <= 1'b1;
        req_type  <= r.kind;
        progress  <= r.prog;
        start_x   <= r.start_v[0];
        start_y   <= r.start_v[1];
        start_z   <= r.start_v[2];
        goal_x    <= r.goal_v[0];
        goal_y    <= r.goal_v[1];
        goal_z    <= r.goal_v[2];
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Drop valid for the given number of cycles (at least one).
    task automatic idle_sender(input int cycles);
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Hold the sender until every predicted word has come back.
    task automatic wait_for_results();
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Random request: mostly real curves with interesting progress, a few unused
    // codes; vector components mix full-range, small and extreme values.
    function automatic ease_req_t random_request();
        ease_req_t r;
        int        pick;
        r.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 5))
                0:       r.prog = 17'd0;
                1:       r.prog = 17'd1;
                2:       r.prog = 17'd32767;
                3:       r.prog = 17'd32768;
                4:       r.prog = 17'd65535;
                default: r.prog = 17'd65536;
            endcase
        end
        else if (pick == 1)
            r.prog = 17'($urandom_range(65537, 131071));
        else
            r.prog = 17'($urandom_range(0, 65536));
        for (int c = 0; c < 6; c++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    pick = int'(EXTREMES[$urandom_range(0, 4)]);
                2, 3, 4: pick = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                default: pick = int'($urandom);
            endcase
            if (c < 3)
                r.start_v[c] = 32'(pick);
            else
                r.goal_v[c - 3] = 32'(pick);
        end
        return r;
    endfunction

    // Monitor: note accepted requests, check returned words and watch for a hang.
    // Both handshakes are sampled at the rising edge; the drivers move at the
    // falling edge, so every sampled value is settled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request('{req_type, progress, {start_z, start_y, start_x},
                                  {goal_z, goal_y, goal_x}});
            if (res_valid && res_ready)
                sb.check_result({value_z, value_y, value_x}, saturated);
            if ((req_valid && req_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles, %0d still due",
                         quiet_cycles, sb.outstanding());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: stretches of its own stall pattern (always ready, coin flip,
    // mostly stalled, alternating), with a long hold-off whenever asked.
    initial
    begin : receiver
        int mode;
        int stretch;
        res_ready = 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(8, 60);
            repeat (stretch)
            begin
                @(negedge clk);
                if (hold_req)
                begin
                    // Hold off for a fixed count while the sender keeps going,
                    // so the queue fills and the block drops req_ready.
                    res_ready <= 1'b0;
                    repeat (HOLD_CYCLES)
                        @(negedge clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0:       res_ready <= 1'b1;
                    1:       res_ready <= 1'($urandom_range(0, 1));
                    2:       res_ready <= ($urandom_range(0, 3) == 0);
                    default: res_ready <= ~res_ready;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        ease_req_t r;
        int        burst_left;
        sb        = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_type  = '0;
        progress  = '0;
        start_x   = '0;
        start_y   = '0;
        start_z   = '0;
        goal_x    = '0;
        goal_y    = '0;
        goal_z    = '0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words, back to back; rotate the vector extremes across them.
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            r.kind = DIR_KIND[i];
            r.prog = DIR_PROG[i];
            for (int c = 0; c < 3; c++)
            begin
                r.start_v[c] = EXTREMES[(i + c) % 5];
                r.goal_v[c]  = EXTREMES[(i + 2 * c + 2) % 5];
            end
            offer_request(r);
        end
        idle_sender(1);
        wait_for_results();
        drain_count++;

        // Random words in bursts with random gaps; twice ask for a long receiver
        // hold-off in the middle of a long burst, twice drain the block fully.
        burst_left = 0;
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n == 300 || n == 800)
            begin
                hold_req = 1'b1;
                hold_count++;
                burst_left = 60;
            end
            if (n == 550 || n == 1000)
            begin
                idle_sender(1);
                wait_for_results();
                drain_count++;
            end
            if (burst_left == 0)
            begin
                idle_sender($urandom_range(1, 16));
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 150)
                                                         : $urandom_range(1, 40);
            end
            offer_request(random_request());
            burst_left--;
        end
        idle_sender(1);

        // Wait for the last words, then a little longer to catch any stray output.
        wait_for_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("covered %0d requests: in-quad %0d, out-quad %0d, in-out %0d, linear %0d, "
                 , sb.requests_seen, sb.curve_seen[0], sb.curve_seen[1], sb.curve_seen[2],
                 sb.curve_seen[3]);
        $display("  in-exp %0d, out-exp %0d, unused codes %0d, progress above one %0d; "
                 , sb.curve_seen[4], sb.curve_seen[5], sb.curve_seen[6] + sb.curve_seen[7],
                 sb.over_one_seen);
        $display("checked %0d words, %0d mismatches, %0d hold-offs, %0d full drains",
                 sb.results_checked, sb.mismatches, hold_count, drain_count);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/vei_pkg.sv
rtl/vei_front.sv
rtl/vei_queue.sv
rtl/vei_curve.sv
rtl/vei_blend.sv
rtl/vector_easing_interpolator.sv
sim/tb_vector_easing_interpolator.sv
